[rtl/pba_pkg.sv]
package pba_pkg;

   localparam int MAX_PAGES  = 4096;
   localparam int WORD_BITS  = 64;
   localparam int MAX_RUN    = 16;
   localparam int WORD_COUNT = MAX_PAGES / WORD_BITS;
   localparam int WORD_AW    = $clog2(WORD_COUNT);
   localparam int BIT_AW     = $clog2(WORD_BITS);
   localparam int SHIFT_W    = BIT_AW + 1;
   localparam int WIN_W      = MAX_RUN;
   localparam int PAGE_SHIFT = 12;
   localparam int ADDR_W     = 52;
   localparam int COUNT_W    = 13;
   localparam int INDEX_W    = 12;
   localparam int RUN_W      = 5;
   localparam int OP_W       = 2;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_CLEAR   = 2'd2
   } op_type;

   typedef enum logic [0:0] {
      CSR_PAGE_COUNT   = 1'b0,
      CSR_BASE_ADDRESS = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MARK_CUR,
      ST_MARK_PREV,
      ST_RELEASE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic start;
      logic clear_map;
      logic scan_step;
      logic mark_cur;
      logic mark_prev;
      logic release_wr;
      logic set_ok;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic            set_up;
      logic [OP_W-1:0] op;
      logic            run_ok;
      logic            idx_ok;
      logic            hit;
      logic            at_last;
      logic            spans;
      logic            rsp_free;
   } status_type;

endpackage

[rtl/pba_ctrl.sv]
module pba_ctrl
   import pba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_FINISH;
               if (status.set_up) begin
                  case (status.op)
                     OP_ALLOC: begin
                        if (status.run_ok) begin
                           state_in = ST_SCAN;
                        end
                     end
                     OP_RELEASE: begin
                        if (status.idx_ok) begin
                           state_in = ST_RELEASE;
                        end
                     end
                     OP_CLEAR: begin
                        cmd.clear_map = 1'b1;
                        cmd.set_ok    = 1'b1;
                     end
                     default: begin
                        state_in = ST_FINISH;
                     end
                  endcase
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.hit) begin
               state_in = ST_MARK_CUR;
            end else if (status.at_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_MARK_CUR: begin
            cmd.mark_cur = 1'b1;
            cmd.set_ok   = 1'b1;
            state_in     = status.spans ? ST_MARK_PREV : ST_FINISH;
         end
         ST_MARK_PREV: begin
            cmd.mark_prev = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_RELEASE: begin
            cmd.release_wr = 1'b1;
            cmd.set_ok     = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_prev_after_cur: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MARK_PREV |-> $past(state_ff) == ST_MARK_CUR)
      else $error("second word written without the first");

   a_scan_continues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !status.hit && !status.at_last) |=> state_ff == ST_SCAN)
      else $error("scan left before the last word");

   a_finish_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && status.rsp_free) |=> state_ff == ST_IDLE)
      else $error("result slot free but controller did not return to idle");

endmodule

[rtl/pba_datapath.sv]
module pba_datapath
   import pba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [0:0]          csr_index,
   input  logic [ADDR_W-1:0]   csr_wdata,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [RUN_W-1:0]    req_run_length,
   input  logic [INDEX_W-1:0]  req_page_index,
   input  cmd_type             cmd,
   output status_type          status,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic                rsp_success,
   output logic [INDEX_W-1:0]  rsp_first_page,
   output logic [ADDR_W-1:0]   rsp_page_address,
   output logic [COUNT_W-1:0]  rsp_used_pages
);

   logic [WORD_BITS-1:0] mem [WORD_COUNT];
   logic [WORD_COUNT-1:0] row_valid_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_vld_ff;

   logic [COUNT_W-1:0]   page_count_ff;
   logic [ADDR_W-1:0]    base_ff;
   logic [COUNT_W-1:0]   used_total_ff;

   logic [OP_W-1:0]      op_ff;
   logic [RUN_W-1:0]     n_ff;
   logic [INDEX_W-1:0]   idx_ff;
   logic [WORD_AW-1:0]   scan_w_ff;
   logic [WIN_W-1:0]     tail_ff;
   logic [WORD_BITS-1:0] cur_hold_ff;
   logic [WORD_BITS-1:0] prev_raw_ff;
   logic [BIT_AW-1:0]    hit_j_ff;
   logic [INDEX_W-1:0]   first_ff;
   logic                 ok_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_success_ff;
   logic [INDEX_W-1:0]   rsp_first_ff;
   logic [ADDR_W-1:0]    rsp_addr_ff;
   logic [COUNT_W-1:0]   rsp_used_ff;

   logic [COUNT_W-1:0]   pages;
   logic [COUNT_W-1:0]   pages_m1;
   logic [WORD_AW-1:0]   last_w;
   logic [BIT_AW-1:0]    lim;
   logic [WORD_AW-1:0]   rd_addr;
   logic [WORD_BITS-1:0] cur_raw;
   logic [WORD_BITS-1:0] in_range;
   logic [WORD_BITS-1:0] free_bits;
   logic [WORD_BITS+WIN_W-1:0] ext;
   logic [WIN_W-1:0]     need;
   logic [WIN_W-1:0]     win;
   logic                 hit;
   logic [BIT_AW-1:0]    hit_pos;
   logic [INDEX_W-1:0]   first_calc;
   logic [WIN_W-1:0]     run_ones;
   logic [SHIFT_W-1:0]   shamt;
   logic [2*WORD_BITS-1:0] mark_mask;
   logic                 wr_en;
   logic [WORD_AW-1:0]   wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic                 was_used;
   logic [ADDR_W-1:0]    addr_calc;

   assign pages    = (page_count_ff > COUNT_W'(MAX_PAGES)) ? COUNT_W'(MAX_PAGES) : page_count_ff;
   assign pages_m1 = pages - COUNT_W'(1);
   assign last_w   = pages_m1[BIT_AW +: WORD_AW];
   assign lim      = pages_m1[BIT_AW-1:0];

   assign status.set_up   = (pages != '0);
   assign status.op       = req_operation;
   assign status.run_ok   = (req_run_length != '0) && (req_run_length <= RUN_W'(MAX_RUN));
   assign status.idx_ok   = ({1'b0, req_page_index} < pages);
   assign status.hit      = hit;
   assign status.at_last  = (scan_w_ff == last_w);
   assign status.spans    = |mark_mask[WORD_BITS-1:0];
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;

   // The first read of an operation is issued in the accept cycle; during a scan the
   // next word is fetched while the current one is checked.
   always_comb begin
      if (cmd.start) begin
         rd_addr = (req_operation == OP_RELEASE) ? req_page_index[BIT_AW +: WORD_AW] : '0;
      end else begin
         rd_addr = scan_w_ff + WORD_AW'(1);
      end
   end

   // Rows never written since reset or clear read as all free.
   assign cur_raw = rd_vld_ff ? rd_data_ff : '0;

   // Pages at or beyond the managed count count as used.
   assign in_range  = (scan_w_ff == last_w) ?
                      ({WORD_BITS{1'b1}} >> (BIT_AW'(WORD_BITS - 1) - lim)) : {WORD_BITS{1'b1}};
   assign free_bits = ~cur_raw & in_range;
   assign ext       = {free_bits, tail_ff};
   assign need      = ~({WIN_W{1'b1}} >> n_ff);

   // A window ending at bit j holds the last WIN_W pages up to j; the run fits when
   // its top n bits are all free. The lowest end gives the lowest start.
   always_comb begin
      hit     = 1'b0;
      hit_pos = '0;
      win     = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         win = ext[j+1 +: WIN_W];
         if ((win & need) == need) begin
            hit     = 1'b1;
            hit_pos = BIT_AW'(j);
         end
      end
   end

   assign first_calc = {scan_w_ff, hit_pos} + INDEX_W'(1) - INDEX_W'(n_ff);

   assign run_ones  = ~({WIN_W{1'b1}} << n_ff);
   assign shamt     = SHIFT_W'(WORD_BITS) + SHIFT_W'(hit_j_ff) + SHIFT_W'(1) - SHIFT_W'(n_ff);
   assign mark_mask = {{(2*WORD_BITS-WIN_W){1'b0}}, run_ones} << shamt;

   assign was_used = cur_raw[idx_ff[BIT_AW-1:0]];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = scan_w_ff;
      wr_data = cur_hold_ff | mark_mask[2*WORD_BITS-1:WORD_BITS];
      if (cmd.mark_cur) begin
         wr_en = 1'b1;
      end else if (cmd.mark_prev) begin
         wr_en   = 1'b1;
         wr_addr = scan_w_ff - WORD_AW'(1);
         wr_data = prev_raw_ff | mark_mask[WORD_BITS-1:0];
      end else if (cmd.release_wr) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff[BIT_AW +: WORD_AW];
         wr_data = cur_raw & ~(WORD_BITS'(1) << idx_ff[BIT_AW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
      rd_vld_ff  <= row_valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_map) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff <= '0;
         base_ff       <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PAGE_COUNT:   page_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_BASE_ADDRESS: base_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_map) begin
         used_total_ff <= '0;
      end else if (cmd.mark_cur) begin
         used_total_ff <= used_total_ff + COUNT_W'(n_ff);
      end else if (cmd.release_wr && was_used) begin
         used_total_ff <= used_total_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff       <= req_operation;
         n_ff        <= req_run_length;
         idx_ff      <= req_page_index;
         scan_w_ff   <= '0;
         tail_ff     <= '0;
         prev_raw_ff <= '0;
         first_ff    <= '0;
      end else if (cmd.scan_step) begin
         cur_hold_ff <= cur_raw;
         if (hit) begin
            hit_j_ff <= hit_pos;
            first_ff <= first_calc;
         end else begin
            prev_raw_ff <= cur_raw;
            tail_ff     <= free_bits[WORD_BITS-1 -: WIN_W];
            scan_w_ff   <= scan_w_ff + WORD_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ok_ff <= 1'b0;
      end else if (cmd.set_ok) begin
         ok_ff <= 1'b1;
      end else if (cmd.start) begin
         ok_ff <= 1'b0;
      end
   end

   assign addr_calc = (ok_ff && op_ff == OP_ALLOC) ?
                      base_ff + ADDR_W'({first_ff, {PAGE_SHIFT{1'b0}}}) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_success_ff <= ok_ff;
         rsp_first_ff   <= first_ff;
         rsp_addr_ff    <= addr_calc;
         rsp_used_ff    <= used_total_ff;
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_success      = rsp_success_ff;
   assign rsp_first_page   = rsp_first_ff;
   assign rsp_page_address = rsp_addr_ff;
   assign rsp_used_pages   = rsp_used_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_total_ff <= COUNT_W'(MAX_PAGES))
      else $error("used page count above the map size");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> scan_w_ff <= last_w)
      else $error("scan past the last managed word");

   a_mark_count: assert property (@(posedge clock) disable iff (reset)
      cmd.mark_cur |=> used_total_ff == $past(used_total_ff) + COUNT_W'($past(n_ff)))
      else $error("used count not advanced by the run length");

endmodule

[rtl/page_bitmap_allocator.sv]
// Each request is handled in steps. An allocation scans bitmap words (1 to 64) until a run
// fits, then marks that word and, when the run crosses a word boundary, the previous word;
// it ends when no run is found. A release rewrites one word; clear and failed checks go
// straight to the result. Items are handled one at a time, with the bitmap scanned one word
// per cycle. Synchronous active-high reset clears the per-word valid bits, the used count,
// both configuration registers and any pending result.
module page_bitmap_allocator
   import pba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,  // operation[1:0], run_length[6:2], page_index[18:7]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [79:0]         rsp_tdata,  // success[0], first_page[12:1],
                                           // page_address[64:13], used_pages[77:65]
   input  logic                csr_we,
   input  logic [0:0]          csr_index,
   input  logic [ADDR_W-1:0]   csr_wdata
);

   cmd_type              cmd;
   status_type           status;
   logic                 rsp_success;
   logic [INDEX_W-1:0]   rsp_first_page;
   logic [ADDR_W-1:0]    rsp_page_address;
   logic [COUNT_W-1:0]   rsp_used_pages;

   pba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pba_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_operation    (req_tdata[1:0]),
      .req_run_length   (req_tdata[6:2]),
      .req_page_index   (req_tdata[18:7]),
      .cmd              (cmd),
      .status           (status),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_success      (rsp_success),
      .rsp_first_page   (rsp_first_page),
      .rsp_page_address (rsp_page_address),
      .rsp_used_pages   (rsp_used_pages)
   );

   assign rsp_tdata = {2'b00, rsp_used_pages, rsp_page_address, rsp_first_page,
                       rsp_success};

endmodule

[test/tb_page_bitmap_allocator.sv]
`timescale 1ns / 1ps

module tb_page_bitmap_allocator;
   import pba_pkg::*;

   localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
   localparam int MISMATCHES_SHOWN = 10;
   localparam int PHASES = 8;

   typedef struct packed {
      logic               success;
      logic [INDEX_W-1:0] first_page;
      logic [ADDR_W-1:0]  address;
      logic [COUNT_W-1:0] used;
   } outcome_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [23:0]       req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [79:0]       rsp_tdata;
   logic              csr_we = 1'b0;
   csr_type           csr_index = CSR_PAGE_COUNT;
   logic [ADDR_W-1:0] csr_wdata = '0;

   // Predictor copy of the bitmap, the used count and both registers.
   logic [MAX_PAGES-1:0] page_map = '0;
   int unsigned          used_count = 0;
   logic [COUNT_W-1:0]   page_count_reg = '0;
   logic [ADDR_W-1:0]    base_reg = '0;

   logic [23:0] request_queue[$];
   outcome_type outcome_queue[$];
   logic        req_taken = 1'b0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   int          errors = 0;
   int          results = 0;
   int          requests = 0;
   int          grants = 0;
   int          releases = 0;
   int          clears = 0;
   outcome_type got, want;

   page_bitmap_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned managed_pages();
      return (page_count_reg > MAX_PAGES) ? MAX_PAGES : page_count_reg;
   endfunction

   function automatic outcome_type predict_outcome(logic [23:0] word);
      logic [OP_W-1:0]    op;
      logic [RUN_W-1:0]   run;
      logic [INDEX_W-1:0] idx;
      int unsigned        pages, free_run, p, first, k;
      outcome_type        r;
      op = word[1:0];
      run = word[6:2];
      idx = word[18:7];
      pages = managed_pages();
      r = '0;
      if (pages != 0) begin
         case (op)
            OP_ALLOC: if (run != 0 && run <= MAX_RUN && run <= pages) begin
               // Count free pages in a row; the first run long enough wins.
               free_run = 0;
               for (p = 0; p < pages && free_run < run; p++)
                  free_run = page_map[p] ? 0 : free_run + 1;
               if (free_run == run) begin
                  first = p - run;
                  for (k = 0; k < run; k++)
                     page_map[first + k] = 1'b1;
                  used_count += run;
                  r.success = 1'b1;
                  r.first_page = INDEX_W'(first);
                  r.address = base_reg + (ADDR_W'(first) << PAGE_SHIFT);
               end
            end
            OP_RELEASE: if (idx < pages) begin
               if (page_map[idx]) begin
                  page_map[idx] = 1'b0;
                  used_count--;
               end
               r.success = 1'b1;
            end
            OP_CLEAR: begin
               page_map = '0;
               used_count = 0;
               r.success = 1'b1;
            end
            default: ;
         endcase
      end
      r.used = used_count[COUNT_W-1:0];
      return r;
   endfunction

   function automatic logic [23:0] pack_item(logic [OP_W-1:0] op, logic [RUN_W-1:0] run,
                                            logic [INDEX_W-1:0] idx);
      return {5'b0, idx, run, op};
   endfunction

   function automatic logic [23:0] random_item(int unsigned pages);
      int unsigned        pick;
      logic [OP_W-1:0]    op;
      logic [RUN_W-1:0]   run;
      logic [INDEX_W-1:0] idx;
      pick = $urandom_range(99);
      op = OP_ALLOC;
      run = $urandom;
      idx = $urandom;
      if (pick < 52) begin
         run = (pick < 30) ? $urandom_range(4, 1) : $urandom_range(MAX_RUN, 1);
      end else if (pick < 57) begin
         run = (pick == 52) ? 0 : $urandom_range(31, MAX_RUN + 1);
      end else if (pick < 95) begin
         op = OP_RELEASE;
         // Mostly pages in range, half of those near the bottom where runs pile up.
         if (pages != 0 && pick < 90) begin
            if ($urandom_range(1))
               idx = $urandom_range(pages - 1);
            else
               idx = $urandom_range(((pages < 128) ? pages : 128) - 1);
         end
      end else if (pick < 97) begin
         op = OP_CLEAR;
      end else begin
         op = OP_UNKNOWN;
      end
      return pack_item(op, run, idx);
   endfunction

   task automatic write_csr(csr_type which, logic [ADDR_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (which == CSR_PAGE_COUNT)
         page_count_reg = value[COUNT_W-1:0];
      else
         base_reg = value;
   endtask

   task automatic drain();
      while (request_queue.size() != 0 || req_tvalid || outcome_queue.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Driver: offers a new request only once the previous one has transferred.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata <= request_queue.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: checks each result against the oldest prediction, then predicts new requests.
   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready && !reset;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[0], rsp_tdata[12:1], rsp_tdata[64:13], rsp_tdata[77:65]};
            if (outcome_queue.size() == 0) begin
               errors++;
               if (errors <= MISMATCHES_SHOWN)
                  $display("Result with no request pending: %h", rsp_tdata);
            end else begin
               want = outcome_queue.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= MISMATCHES_SHOWN)
                     $display({"Mismatch on result %0d: expected ok=%0b page=%0d addr=%h ",
                               "used=%0d, got ok=%0b page=%0d addr=%h used=%0d"},
                              results, want.success, want.first_page, want.address,
                              want.used, got.success, got.first_page, got.address, got.used);
               end
               results++;
            end
         end
         if (req_tvalid && req_tready) begin
            want = predict_outcome(req_tdata);
            outcome_queue.push_back(want);
            requests++;
            if (req_tdata[1:0] == OP_ALLOC && want.success)
               grants++;
            if (req_tdata[1:0] == OP_RELEASE)
               releases++;
            if (req_tdata[1:0] == OP_CLEAR)
               clears++;
         end
      end
   end

   initial begin
      int unsigned       pages;
      logic [ADDR_W-1:0] base;
      int                ph, i, count;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Before any setup every operation must fail.
      request_queue.push_back(pack_item(OP_ALLOC, 1, 0));
      request_queue.push_back(pack_item(OP_RELEASE, 0, 0));
      request_queue.push_back(pack_item(OP_CLEAR, 0, 0));
      request_queue.push_back(pack_item(OP_UNKNOWN, 0, 0));
      drain();

      write_csr(CSR_BASE_ADDRESS, 52'hF_FFFF_FFFF_E000);
      write_csr(CSR_PAGE_COUNT, 64);
      request_queue.push_back(pack_item(OP_ALLOC, 0, 0));
      request_queue.push_back(pack_item(OP_ALLOC, MAX_RUN + 1, 0));
      request_queue.push_back(pack_item(OP_ALLOC, 31, 0));
      request_queue.push_back(pack_item(OP_ALLOC, 1, 0));
      request_queue.push_back(pack_item(OP_ALLOC, MAX_RUN, 0));
      request_queue.push_back(pack_item(OP_ALLOC, MAX_RUN, 0));
      request_queue.push_back(pack_item(OP_ALLOC, MAX_RUN, 0));
      // Only 15 pages remain at the top, so a full-length run cannot fit.
      request_queue.push_back(pack_item(OP_ALLOC, MAX_RUN, 0));
      request_queue.push_back(pack_item(OP_ALLOC, 15, 0));
      request_queue.push_back(pack_item(OP_ALLOC, 1, 0));
      request_queue.push_back(pack_item(OP_RELEASE, 0, 64));
      request_queue.push_back(pack_item(OP_RELEASE, 0, 12'hFFF));
      request_queue.push_back(pack_item(OP_RELEASE, 0, 63));
      request_queue.push_back(pack_item(OP_RELEASE, 0, 63));
      request_queue.push_back(pack_item(OP_RELEASE, 0, 10));
      request_queue.push_back(pack_item(OP_ALLOC, 2, 0));
      request_queue.push_back(pack_item(OP_ALLOC, 1, 0));
      request_queue.push_back(pack_item(OP_UNKNOWN, 5, 3));
      request_queue.push_back(pack_item(OP_CLEAR, 0, 0));
      request_queue.push_back(pack_item(OP_ALLOC, MAX_RUN, 0));
      drain();

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: pages = 64;
            1: pages = 100;
            2: pages = 8191;
            3: pages = 5;
            4: pages = MAX_PAGES;
            5: pages = 1;
            6: pages = $urandom_range(MAX_PAGES, 2);
            default: pages = 0;
         endcase
         base = {$urandom, $urandom};
         if (ph == 0)
            base = '0;
         else if (ph == 1 || ph == 4)
            base = '1;
         send_idle_pct = 0;
         recv_stall_pct = 0;
         case (ph % 4)
            1: send_idle_pct = 86;
            2: recv_stall_pct = 86;
            3: begin
               send_idle_pct = 28;
               recv_stall_pct = 28;
            end
            default: ;
         endcase
         write_csr(CSR_BASE_ADDRESS, base);
         write_csr(CSR_PAGE_COUNT, pages);
         count = (pages == 0) ? 60 : 190;
         for (i = 0; i < count; i++)
            request_queue.push_back(random_item(managed_pages()));
         drain();
      end

      if (outcome_queue.size() != 0)
         errors++;
      $display("Ran %0d requests over %0d register settings:", requests, PHASES + 2);
      $display("%0d runs granted, %0d releases, %0d clears; checked %0d results, %0d mismatches.",
               grants, releases, clears, results, errors);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
